// File: design/mpfd_pkg.sv
// package for the page-organised monochrome frame buffer draw engine
// holds geometry constants, command codes and the store request types
// no dependencies
`timescale 1ns / 1ps

package mpfd_pkg;

	// frame geometry
	localparam int unsigned WIDTH      = 128;
	localparam int unsigned PAGES      = 8;
	localparam int unsigned STORE_SIZE = WIDTH * PAGES;
	localparam int unsigned MEM_AW     = $clog2(STORE_SIZE);

	// address arithmetic width: highest start address plus one page step
	localparam int unsigned CALC_W = $clog2(33 * WIDTH + 257);
	// step counter width: covers a clear sweep and an 8-bit span
	localparam int unsigned CNT_W  = $clog2(STORE_SIZE + 256);

	// command codes
	localparam logic [2:0] ACT_PLOT   = 3'd0;
	localparam logic [2:0] ACT_HLINE  = 3'd1;
	localparam logic [2:0] ACT_VLINE  = 3'd2;
	localparam logic [2:0] ACT_INVERT = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;
	localparam logic [2:0] ACT_READ   = 3'd5;

	// pixel combine modes
	localparam logic [1:0] MODE_XOR = 2'd0;
	localparam logic [1:0] MODE_SET = 2'd1;

	// byte operations of the read-modify-write unit
	typedef enum logic [1:0] {
		OP_MODE,
		OP_INV,
		OP_ZERO,
		OP_READ
	} mpfd_op_t;

	typedef struct packed {
		logic              valid;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        mask;
		mpfd_op_t          op;
	} mpfd_req_t;

	typedef struct packed {
		logic       read_valid;
		logic [7:0] data;
	} mpfd_rsp_t;

endpackage

// File: design/mpfd_store.sv
// frame store with a one-byte-per-cycle read-modify-write stage
// depends on mpfd_pkg
`timescale 1ns / 1ps

module mpfd_store (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       plot_mode,
	input  mpfd_pkg::mpfd_req_t req,
	output mpfd_pkg::mpfd_rsp_t rsp
);
	import mpfd_pkg::*;

	logic [7:0]        mem [STORE_SIZE];
	logic [7:0]        rdata_q;
	logic              valid_s1;
	logic [MEM_AW-1:0] addr_s1;
	logic [7:0]        mask_s1;
	mpfd_op_t          op_s1;
	logic [7:0]        mode_byte;
	logic [7:0]        wdata;

	// request stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	// request stage payload
	always_ff @(posedge clk) begin
		addr_s1 <= req.addr;
		mask_s1 <= req.mask;
		op_s1   <= req.op;
	end

	// memory: registered read, written back in the following cycle
	always_ff @(posedge clk) begin
		if (req.valid) begin
			rdata_q <= mem[req.addr];
		end
		if (valid_s1 && op_s1 != OP_READ) begin
			mem[addr_s1] <= wdata;
		end
	end

	// pixel combine: set bits unless xor, then xor unless set
	always_comb begin
		mode_byte = rdata_q;
		if (plot_mode != MODE_XOR) begin
			mode_byte = mode_byte | mask_s1;
		end
		if (plot_mode != MODE_SET) begin
			mode_byte = mode_byte ^ mask_s1;
		end
	end

	// write data select
	always_comb begin
		unique case (op_s1)
			OP_MODE: begin
				wdata = mode_byte;
			end
			OP_INV: begin
				wdata = ~rdata_q;
			end
			OP_ZERO: begin
				wdata = 8'd0;
			end
			OP_READ: begin
				wdata = rdata_q;
			end
			default: begin
				wdata = rdata_q;
			end
		endcase
	end

	assign rsp.read_valid = valid_s1 && (op_s1 == OP_READ);
	assign rsp.data       = rdata_q;

endmodule

// File: design/mono_page_framebuffer_draw_top.sv
// top level of the page-organised monochrome frame buffer draw engine
// command sequencer; depends on mpfd_pkg and mpfd_store
`timescale 1ns / 1ps

// One drawing command is taken when start is high and busy is low; busy then stays
// high until the command is finished, and done pulses for exactly one cycle with
// read_data (the stored byte for a read, zero for every other command). The
// receiver cannot hold done off. The sequencer walks the affected bytes one per
// cycle through a single read-modify-write unit on the frame memory, between a
// setup state and a flush state: plot and read touch at most one byte, a horizontal
// line up to |length| bytes, a vertical line up to one byte per page in the store,
// an invert span up to 255 bytes, and a clear all STORE_SIZE bytes. After reset the
// memory is swept to zero with busy high; plot_mode may be written at any time the
// block is idle, including during that sweep.
module mono_page_framebuffer_draw_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        action,
	input  logic [7:0]        x_pos,
	input  logic [7:0]        y_pos,
	input  logic signed [7:0] length,
	input  logic [7:0]        pattern,
	output logic              done,
	output logic [7:0]        read_data
);
	import mpfd_pkg::*;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	localparam logic [CALC_W-1:0] LAST_ADDR = CALC_W'(STORE_SIZE - 1);
	localparam logic [CALC_W-1:0] STORE_END = CALC_W'(STORE_SIZE);
	localparam logic [CALC_W-1:0] PAGE_STEP = CALC_W'(WIDTH);
	localparam logic [CALC_W-1:0] ADDR_ONE  = CALC_W'(1);
	localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

	logic [2:0]        state_q, state_d;
	logic [1:0]        plot_mode_q;
	logic [2:0]        act_q;
	logic [7:0]        x_q;
	logic [7:0]        y_q;
	logic [7:0]        len_q;
	logic [7:0]        pat_q, pat_d;
	logic [CALC_W-1:0] addr_q, addr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [9:0]        h_q, h_d;
	logic [2:0]        bit_q, bit_d;
	logic              first_q, first_d;
	logic              done_q;
	logic [7:0]        read_data_q;

	logic              accept;
	logic              in_range;
	logic [8:0]        mag;
	logic [7:0]        xs;
	logic [7:0]        ys;
	logic [7:0]        span_end;
	logic [CALC_W-1:0] start_addr;
	logic [9:0]        first_sum;
	logic [7:0]        first_mask;

	mpfd_req_t         req;
	mpfd_rsp_t         rsp;

	// bits below n set, n from 0 to 8
	function automatic logic [7:0] low_mask(input logic [3:0] n);
		logic [8:0] one_bit;
		one_bit  = 9'd1 << n;
		low_mask = 8'(one_bit - 9'd1);
	endfunction

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign in_range = (addr_q < STORE_END);

	// start geometry: a negative length moves the start left or up
	always_comb begin
		mag      = len_q[7] ? (9'd0 - {1'b1, len_q}) : {1'b0, len_q};
		xs       = (act_q == ACT_HLINE && len_q[7]) ? (x_q + len_q) : x_q;
		ys       = (act_q == ACT_VLINE && len_q[7]) ? (y_q + len_q) : y_q;
		span_end = x_q + len_q;
		start_addr = CALC_W'(ys[7:3]) * PAGE_STEP + CALC_W'(xs);
	end

	// first partial page of a vertical line
	always_comb begin
		first_sum  = 10'(bit_q) + h_q;
		first_mask = ~low_mask({1'b0, bit_q});
		if (first_sum < 10'd8) begin
			first_mask = first_mask & low_mask(first_sum[3:0]);
		end
	end

	// sequencer: at most one store request per cycle
	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		cnt_d     = cnt_q;
		h_d       = h_q;
		pat_d     = pat_q;
		bit_d     = bit_q;
		first_d   = first_q;
		req.valid = 1'b0;
		req.addr  = addr_q[MEM_AW-1:0];
		req.mask  = 8'd1 << bit_q;
		req.op    = OP_MODE;
		if (accept) begin
			pat_d = pattern;
		end
		unique case (state_q)
			ST_INIT: begin
				req.valid = 1'b1;
				req.op    = OP_ZERO;
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end else begin
					addr_d = addr_q + ADDR_ONE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_RUN;
				addr_d  = (act_q == ACT_CLEAR) ? '0 : start_addr;
				h_d     = {1'b0, mag};
				bit_d   = ys[2:0];
				first_d = (ys[2:0] != 3'd0);
				if (act_q == ACT_HLINE) begin
					cnt_d = CNT_W'(mag);
				end else if (act_q == ACT_INVERT && span_end > x_q) begin
					cnt_d = CNT_W'(span_end - x_q);
				end else begin
					cnt_d = '0;
				end
			end
			ST_RUN: begin
				unique case (act_q)
					ACT_PLOT: begin
						req.valid = in_range;
						state_d   = ST_FLUSH;
					end
					ACT_READ: begin
						req.valid = in_range;
						req.op    = OP_READ;
						state_d   = ST_FLUSH;
					end
					ACT_CLEAR: begin
						req.valid = 1'b1;
						req.op    = OP_ZERO;
						if (addr_q == LAST_ADDR) begin
							state_d = ST_FLUSH;
						end else begin
							addr_d = addr_q + ADDR_ONE;
						end
					end
					ACT_HLINE: begin
						// stipple: a set bit writes and rotates back in
						if (cnt_q == '0 || !in_range) begin
							state_d = ST_FLUSH;
						end else begin
							req.valid = pat_q[0];
							pat_d     = {pat_q[0], pat_q[7:1]};
							addr_d    = addr_q + ADDR_ONE;
							cnt_d     = cnt_q - CNT_ONE;
						end
					end
					ACT_INVERT: begin
						if (cnt_q == '0 || !in_range) begin
							state_d = ST_FLUSH;
						end else begin
							req.valid = 1'b1;
							req.op    = OP_INV;
							addr_d    = addr_q + ADDR_ONE;
							cnt_d     = cnt_q - CNT_ONE;
						end
					end
					ACT_VLINE: begin
						// partial first page, full pages, then partial last page
						if (!in_range) begin
							state_d = ST_FLUSH;
						end else if (first_q) begin
							req.valid = 1'b1;
							req.mask  = first_mask;
							h_d       = h_q - (10'd8 - 10'(bit_q));
							addr_d    = addr_q + PAGE_STEP;
							first_d   = 1'b0;
						end else if (!h_q[9] && h_q >= 10'd8) begin
							req.valid = 1'b1;
							req.mask  = 8'hFF;
							h_d       = h_q - 10'd8;
							addr_d    = addr_q + PAGE_STEP;
						end else if (!h_q[9] && h_q != 10'd0) begin
							req.valid = 1'b1;
							req.mask  = low_mask(h_q[3:0]);
							state_d   = ST_FLUSH;
						end else begin
							state_d = ST_FLUSH;
						end
					end
					default: begin
						state_d = ST_FLUSH;
					end
				endcase
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			plot_mode_q <= MODE_XOR;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			done_q  <= (state_q == ST_FLUSH);
			if (cfg_we) begin
				plot_mode_q <= cfg_wdata;
			end
		end
	end

	// item and step payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			x_q   <= x_pos;
			y_q   <= y_pos;
			len_q <= length;
		end
		pat_q   <= pat_d;
		cnt_q   <= cnt_d;
		h_q     <= h_d;
		bit_q   <= bit_d;
		first_q <= first_d;
		if (state_q == ST_FLUSH) begin
			read_data_q <= rsp.read_valid ? rsp.data : 8'd0;
		end
	end

	mpfd_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.plot_mode (plot_mode_q),
		.req       (req),
		.rsp       (rsp)
	);

	assign done      = done_q;
	assign read_data = read_data_q;

	// an accepted item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// a result only ends a command
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a command in flight");

	// only a read returns data
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && act_q != ACT_READ |-> read_data == 8'd0)
		else $error("nonzero read_data on a non-read command");

	// no store access past the end of the frame
	a_req_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> in_range)
		else $error("store request out of range");

endmodule

// File: tb/tb_mono_page_framebuffer_draw_top.sv
// self-checking testbench for the page-organised monochrome frame buffer draw engine
// drives draw commands, predicts each returned byte from a shadow frame store
// depends on mpfd_pkg and mono_page_framebuffer_draw_top
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_draw_top;
	import mpfd_pkg::*;

	// combine modes and command codes the package does not name
	localparam logic [1:0] MODE_CLR   = 2'd2;
	localparam logic [1:0] MODE_ODD   = 2'd3;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	localparam int STALL_LIMIT  = 8000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int QUIET_PHASE  = 5;
	localparam int DIR_N        = 26;
	localparam int PRINT_MAX    = 40;

	// plot mode per random phase, phase 0 in the low bits
	localparam logic [2*PHASES-1:0] MODE_SEQ = {MODE_CLR, MODE_XOR, MODE_SET, MODE_ODD,
		MODE_SET, MODE_CLR, MODE_XOR, MODE_SET};

	typedef struct packed {
		logic [2:0] act;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] len;
		logic [7:0] pat;
	} draw_cmd_t;

	typedef struct packed {
		draw_cmd_t  cmd;
		logic       fixed;
		logic [7:0] want;
	} dir_row_t;

	typedef struct packed {
		logic [2:0] act;
		logic [7:0] data;
	} rd_expect_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_wdata = 2'd0;
	logic              start = 1'b0;
	logic              busy;
	logic [2:0]        action = 3'd0;
	logic [7:0]        x_pos = 8'd0;
	logic [7:0]        y_pos = 8'd0;
	logic signed [7:0] length = 8'sd0;
	logic [7:0]        pattern = 8'd0;
	logic              done;
	logic [7:0]        read_data;

	// shadow copy of the block state
	logic [7:0] shadow_frame [STORE_SIZE];
	logic [1:0] shadow_mode = MODE_XOR;

	rd_expect_t expected_bytes [$];
	rd_expect_t mon_exp;
	int         items_sent = 0;
	int         results_seen = 0;
	int         mismatch_cnt = 0;
	int         stall_cnt = 0;

	// directed items; a fixed byte is checked as typed, the rest against the shadow store
	dir_row_t dir_tab [DIR_N] = '{
		'{'{ACT_READ,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, 8'h00}, // read after reset
		'{'{ACT_READ,   8'd255, 8'd255, 8'd0,   8'h00}, 1'b1, 8'h00}, // read out of range
		'{'{ACT_PLOT,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, 8'h00},
		'{'{ACT_READ,   8'd0,   8'd0,   8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_PLOT,   8'd255, 8'd255, 8'd0,   8'h00}, 1'b1, 8'h00}, // dropped write
		'{'{ACT_PLOT,   8'd127, 8'd63,  8'd0,   8'h00}, 1'b1, 8'h00}, // last pixel
		'{'{ACT_READ,   8'd127, 8'd63,  8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_HLINE,  8'd10,  8'd3,   8'h7F,  8'hA5}, 1'b1, 8'h00}, // longest positive
		'{'{ACT_READ,   8'd20,  8'd3,   8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_HLINE,  8'd200, 8'd9,   8'h80,  8'hFF}, 1'b1, 8'h00}, // length -128
		'{'{ACT_READ,   8'd8,   8'd16,  8'd0,   8'h00}, 1'b0, 8'h00}, // spilled column
		'{'{ACT_HLINE,  8'd120, 8'd63,  8'd100, 8'h01}, 1'b1, 8'h00}, // runs off the store
		'{'{ACT_HLINE,  8'd0,   8'd0,   8'd20,  8'h00}, 1'b1, 8'h00}, // empty stipple
		'{'{ACT_VLINE,  8'd3,   8'd5,   8'd2,   8'h00}, 1'b1, 8'h00}, // inside one page
		'{'{ACT_READ,   8'd3,   8'd0,   8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_VLINE,  8'd4,   8'd3,   8'd40,  8'h00}, 1'b1, 8'h00}, // partial both ends
		'{'{ACT_READ,   8'd4,   8'd16,  8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_VLINE,  8'd6,   8'd130, 8'h80,  8'h00}, 1'b1, 8'h00}, // wraps up to row 2
		'{'{ACT_READ,   8'd6,   8'd24,  8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_INVERT, 8'd250, 8'd0,   8'd10,  8'h00}, 1'b1, 8'h00}, // end wraps, no-op
		'{'{ACT_INVERT, 8'd0,   8'd56,  8'hFF,  8'h00}, 1'b1, 8'h00}, // widest span
		'{'{ACT_READ,   8'd100, 8'd56,  8'd0,   8'h00}, 1'b0, 8'h00},
		'{'{ACT_SPARE6, 8'd1,   8'd1,   8'd1,   8'h01}, 1'b1, 8'h00},
		'{'{ACT_SPARE7, 8'd2,   8'd2,   8'd2,   8'h02}, 1'b1, 8'h00},
		'{'{ACT_CLEAR,  8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, 8'h00},
		'{'{ACT_READ,   8'd4,   8'd16,  8'd0,   8'h00}, 1'b1, 8'h00}  // gone after clear
	};

	mono_page_framebuffer_draw_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.length    (length),
		.pattern   (pattern),
		.done      (done),
		.read_data (read_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned frame_addr(logic [7:0] x, logic [7:0] y);
		return int'(y[7:3]) * WIDTH + int'(x);
	endfunction

	// one byte write, combined by the current plot mode, dropped past the store
	function automatic void merge_bits(int unsigned addr, logic [7:0] mask);
		logic [7:0] v;
		if (addr >= STORE_SIZE)
			return;
		v = shadow_frame[addr];
		if (shadow_mode != MODE_XOR)
			v = v | mask;
		if (shadow_mode != MODE_SET)
			v = v ^ mask;
		shadow_frame[addr] = v;
	endfunction

	// updates the shadow store for one command and returns the byte it reports
	function automatic logic [7:0] apply_draw_cmd(draw_cmd_t c);
		int          span;
		int          yb;
		int unsigned addr;
		logic [7:0]  xs;
		logic [7:0]  ys;
		logic [7:0]  pat;
		logic [7:0]  msk;
		logic [7:0]  stop;
		logic [7:0]  rd;
		rd = 8'h00;
		span = int'($signed(c.len));
		case (c.act)
			ACT_PLOT: begin
				merge_bits(frame_addr(c.x, c.y), 8'd1 << c.y[2:0]);
			end
			ACT_HLINE: begin
				xs = c.x;
				pat = c.pat;
				msk = 8'd1 << c.y[2:0];
				if (span < 0) begin
					xs = c.x + c.len;
					span = -span;
				end
				addr = frame_addr(xs, c.y);
				// stipple: a set bit writes and rotates back in, a clear bit shifts out
				for (int i = 0; i < span && addr < STORE_SIZE; i++) begin
					if (pat[0]) begin
						merge_bits(addr, msk);
						pat = {1'b1, pat[7:1]};
					end else begin
						pat = {1'b0, pat[7:1]};
					end
					addr++;
				end
			end
			ACT_VLINE: begin
				ys = c.y;
				if (span < 0) begin
					ys = c.y + c.len;
					span = -span;
				end
				addr = frame_addr(c.x, ys);
				yb = int'(ys[2:0]);
				// first page from the start row up, trimmed if the line ends inside it
				if (yb != 0) begin
					msk = 8'hFF << yb;
					span -= 8 - yb;
					if (span < 0)
						msk &= 8'((1 << (8 + span)) - 1);
					merge_bits(addr, msk);
					addr += WIDTH;
				end
				while (span >= 8) begin
					span -= 8;
					merge_bits(addr, 8'hFF);
					addr += WIDTH;
				end
				if (span > 0)
					merge_bits(addr, 8'((1 << span) - 1));
			end
			ACT_INVERT: begin
				stop = c.x + c.len;
				addr = frame_addr(c.x, c.y);
				for (int xi = int'(c.x); xi < int'(stop); xi++) begin
					if (addr < STORE_SIZE)
						shadow_frame[addr] ^= 8'hFF;
					addr++;
				end
			end
			ACT_CLEAR: begin
				foreach (shadow_frame[k])
					shadow_frame[k] = 8'h00;
			end
			ACT_READ: begin
				addr = frame_addr(c.x, c.y);
				if (addr < STORE_SIZE)
					rd = shadow_frame[addr];
			end
			default: ;
		endcase
		return rd;
	endfunction

	// hold start until the item is taken, then record the byte it should return
	task automatic issue_cmd(input draw_cmd_t c, input logic fixed, input logic [7:0] want);
		rd_expect_t e;
		logic [7:0] predicted;
		start <= 1'b1;
		action <= c.act;
		x_pos <= c.x;
		y_pos <= c.y;
		length <= c.len;
		pattern <= c.pat;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_draw_cmd(c);
		e.act = c.act;
		e.data = fixed ? want : predicted;
		expected_bytes.push_back(e);
		items_sent++;
	endtask

	// random pause of the sender between items
	task automatic sender_gap(input bit allow_idle);
		if (allow_idle && $urandom_range(0, 99) < 35) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0 || busy)
			@(posedge clk);
	endtask

	// result checker and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_bytes.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= PRINT_MAX)
						$display("%0t: done with no item outstanding, read_data %02h",
							$time, read_data);
				end else begin
					mon_exp = expected_bytes.pop_front();
					results_seen++;
					if (read_data !== mon_exp.data) begin
						mismatch_cnt++;
						if (mismatch_cnt <= PRINT_MAX)
							$display("%0t: read_data for action %0d: expected %02h, got %02h",
								$time, mon_exp.act, mon_exp.data, read_data);
					end
				end
			end
			if (done || (start && !busy))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		draw_cmd_t c;
		int        sel;
		foreach (shadow_frame[k])
			shadow_frame[k] = 8'h00;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed items under the reset plot mode
		for (int r = 0; r < DIR_N; r++) begin
			issue_cmd(dir_tab[r].cmd, dir_tab[r].fixed, dir_tab[r].want);
			sender_gap(1'b1);
		end

		// random phases, one plot mode each, written while the engine is idle
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			cfg_we <= 1'b1;
			cfg_wdata <= MODE_SEQ[2*p +: 2];
			shadow_mode = MODE_SEQ[2*p +: 2];
			@(posedge clk);
			cfg_we <= 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 20)
					c.act = ACT_PLOT;
				else if (sel < 34)
					c.act = ACT_HLINE;
				else if (sel < 48)
					c.act = ACT_VLINE;
				else if (sel < 58)
					c.act = ACT_INVERT;
				else if (sel < 59)
					c.act = ACT_CLEAR;
				else if (sel < 60)
					c.act = ACT_SPARE6;
				else if (sel < 61)
					c.act = ACT_SPARE7;
				else
					c.act = ACT_READ;
				// mostly on screen, sometimes anywhere in the coordinate range
				c.x = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 127))
					: 8'($urandom_range(0, 255));
				c.y = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 63))
					: 8'($urandom_range(0, 255));
				c.len = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 32) - 16);
				c.pat = 8'($urandom_range(0, 255));
				issue_cmd(c, 1'b0, 8'h00);
				sender_gap(p != QUIET_PHASE);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("summary: %0d draw items (%0d directed) over %0d plot mode phases,",
			items_sent, DIR_N, PHASES);
		$display("summary: %0d bytes returned and checked, %0d mismatches",
			results_seen, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_bytes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
design/mpfd_pkg.sv
design/mpfd_store.sv
design/mono_page_framebuffer_draw_top.sv
tb/tb_mono_page_framebuffer_draw_top.sv
